### src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the scroll stepper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check, ignored while reset is asserted.
`define MSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("marquee scroll stepper check failed");

// Clocked check that also holds during reset.
`define MSS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("marquee scroll stepper check failed");

`else

`define MSS_ASSERT(lbl, prop)
`define MSS_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### src/mss_pkg.sv
// Package: types, constants and helper functions of the scroll stepper.
`timescale 1ns / 1ps

package mss_pkg;

  localparam int COORD_WIDTH = 16;              // position register width
  localparam int EXT_WIDTH   = COORD_WIDTH + 2; // room for position + text size
  localparam int OUT_WIDTH   = 16;
  localparam int SIZE_WIDTH  = 12;
  localparam int SPEED_WIDTH = 8;
  localparam int PAUSE_WIDTH = 16;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 16;

  localparam logic signed [SPEED_WIDTH-1:0] SPEED_MIN = 8'sh80;
  localparam logic signed [SPEED_WIDTH-1:0] SPEED_MAX = 8'sh7f;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_WRAP   = 2'd1,
    MODE_BOUNCE = 2'd2,
    MODE_ONCE   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_MODE          = 3'd0,
    REG_START_SPEED_X = 3'd1,
    REG_START_SPEED_Y = 3'd2,
    REG_GAP           = 3'd3,
    REG_PAUSE_LEN     = 3'd4,
    REG_WINDOW_WIDTH  = 3'd5,
    REG_WINDOW_HEIGHT = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    mode_e                          mode;
    logic signed [SPEED_WIDTH-1:0]  start_speed_x;
    logic signed [SPEED_WIDTH-1:0]  start_speed_y;
    logic [SIZE_WIDTH-1:0]          gap;
    logic [PAUSE_WIDTH-1:0]         pause_len;
    logic [SIZE_WIDTH-1:0]          window_width;
    logic [SIZE_WIDTH-1:0]          window_height;
  } cfg_t;

  typedef struct packed {
    logic                  restart;
    logic [SIZE_WIDTH-1:0] text_width;
    logic [SIZE_WIDTH-1:0] text_height;
  } item_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] offset_x;
    logic signed [OUT_WIDTH-1:0] offset_y;
    logic signed [OUT_WIDTH-1:0] repeat_x;
    logic signed [OUT_WIDTH-1:0] repeat_y;
    logic                        active;
    logic                        unscrolled;
  } result_t;

  // Sign-extend or truncate a position to the output width.
  function automatic logic signed [OUT_WIDTH-1:0] coord_to_out(
    input logic signed [COORD_WIDTH-1:0] v
  );
    logic signed [COORD_WIDTH+OUT_WIDTH-1:0] t;
    t = (COORD_WIDTH + OUT_WIDTH)'(v);
    return t[OUT_WIDTH-1:0];
  endfunction

  // Sign-extend or truncate an extended value to the output width.
  function automatic logic signed [OUT_WIDTH-1:0] ext_to_out(
    input logic signed [EXT_WIDTH-1:0] v
  );
    logic signed [EXT_WIDTH+OUT_WIDTH-1:0] t;
    t = (EXT_WIDTH + OUT_WIDTH)'(v);
    return t[OUT_WIDTH-1:0];
  endfunction

  // Negate a speed, saturating the most negative value.
  function automatic logic signed [SPEED_WIDTH-1:0] neg_speed(
    input logic signed [SPEED_WIDTH-1:0] s
  );
    return (s == SPEED_MIN) ? SPEED_MAX : -s;
  endfunction

endpackage

### src/mss_in_if.sv
// Interface: input item channel of the scroll stepper.
`timescale 1ns / 1ps

interface mss_in_if import mss_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  restart;
  logic [SIZE_WIDTH-1:0] text_width;
  logic [SIZE_WIDTH-1:0] text_height;

  modport source (output valid, restart, text_width, text_height, input ready);
  modport sink   (input valid, restart, text_width, text_height, output ready);
endinterface

### src/mss_out_if.sv
// Interface: result channel of the scroll stepper.
`timescale 1ns / 1ps

interface mss_out_if import mss_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] offset_x;
  logic signed [OUT_WIDTH-1:0] offset_y;
  logic signed [OUT_WIDTH-1:0] repeat_x;
  logic signed [OUT_WIDTH-1:0] repeat_y;
  logic                        active;
  logic                        unscrolled;

  modport source (output valid, offset_x, offset_y, repeat_x, repeat_y, active,
                  unscrolled, input ready);
  modport sink   (input valid, offset_x, offset_y, repeat_x, repeat_y, active,
                  unscrolled, output ready);
endinterface

### src/mss_cfg_if.sv
// Interface: configuration write channel of the scroll stepper.
`timescale 1ns / 1ps

interface mss_cfg_if import mss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_IDX_WIDTH-1:0]  index;
  logic [CFG_DATA_WIDTH-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/mss_cfg_regs.sv
// Configuration register file of the scroll stepper.
`timescale 1ns / 1ps

module mss_cfg_regs import mss_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  mss_cfg_if.sink cfg_i,
  output cfg_t  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_MODE:          cfg_d.mode          = mode_e'(cfg_i.data[1:0]);
        REG_START_SPEED_X: cfg_d.start_speed_x = cfg_i.data[SPEED_WIDTH-1:0];
        REG_START_SPEED_Y: cfg_d.start_speed_y = cfg_i.data[SPEED_WIDTH-1:0];
        REG_GAP:           cfg_d.gap           = cfg_i.data[SIZE_WIDTH-1:0];
        REG_PAUSE_LEN:     cfg_d.pause_len     = cfg_i.data[PAUSE_WIDTH-1:0];
        REG_WINDOW_WIDTH:  cfg_d.window_width  = cfg_i.data[SIZE_WIDTH-1:0];
        REG_WINDOW_HEIGHT: cfg_d.window_height = cfg_i.data[SIZE_WIDTH-1:0];
        default:           cfg_d = cfg_q;  // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/mss_step_core.sv
// Scroll state registers and the per-tick update logic.
`timescale 1ns / 1ps

module mss_step_core import mss_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    step_i,
  input  item_t   item_i,
  output result_t result_o
);

  localparam int EW = EXT_WIDTH;
  localparam int CW = COORD_WIDTH;

  logic signed [CW-1:0]          pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [SPEED_WIDTH-1:0] speed_x_q, speed_x_d, speed_y_q, speed_y_d;
  logic [PAUSE_WIDTH-1:0]        pause_q, pause_d;

  logic signed [EW-1:0] tw_e, th_e, ww_m1, wh_m1, ox_e, oy_e;
  logic signed [EW-1:0] nx_e, ny_e, mvx_e, mvy_e;
  logic signed [CW-1:0] rst_x, rst_y, mv_x, mv_y;
  logic                 gt_x, lt_x, gt_y, lt_y, sgt_x, slt_x, sgt_y, slt_y;
  logic                 scroll_mode, too_small, hit, rev_x, rev_y;

  always_comb begin
    tw_e  = $signed(EW'(item_i.text_width));
    th_e  = $signed(EW'(item_i.text_height));
    ww_m1 = $signed(EW'(cfg_i.window_width)) - $signed(EW'(1));
    wh_m1 = $signed(EW'(cfg_i.window_height)) - $signed(EW'(1));
    ox_e  = EW'(pos_x_q);
    oy_e  = EW'(pos_y_q);

    gt_x = !speed_x_q[SPEED_WIDTH-1] && (speed_x_q != '0);
    lt_x = speed_x_q[SPEED_WIDTH-1];
    gt_y = !speed_y_q[SPEED_WIDTH-1] && (speed_y_q != '0);
    lt_y = speed_y_q[SPEED_WIDTH-1];

    // Restart position: enter from the side the text moves away from
    sgt_x = !cfg_i.start_speed_x[SPEED_WIDTH-1] && (cfg_i.start_speed_x != '0);
    slt_x = cfg_i.start_speed_x[SPEED_WIDTH-1];
    sgt_y = !cfg_i.start_speed_y[SPEED_WIDTH-1] && (cfg_i.start_speed_y != '0);
    slt_y = cfg_i.start_speed_y[SPEED_WIDTH-1];
    scroll_mode = (cfg_i.mode == MODE_WRAP) || (cfg_i.mode == MODE_ONCE);
    rst_x = '0;
    rst_y = '0;
    if (scroll_mode) begin
      if (sgt_x)      rst_x = CW'(-tw_e);
      else if (slt_x) rst_x = CW'(ww_m1);
      if (sgt_y)      rst_y = CW'(-th_e);
      else if (slt_y) rst_y = CW'(wh_m1);
    end

    // Repeat step: minus the direction times the period
    nx_e = '0;
    ny_e = '0;
    if (gt_x)      nx_e = -($signed(EW'(cfg_i.gap)) + tw_e);
    else if (lt_x) nx_e = $signed(EW'(cfg_i.gap)) + tw_e;
    if (gt_y)      ny_e = -($signed(EW'(cfg_i.gap)) + th_e);
    else if (lt_y) ny_e = $signed(EW'(cfg_i.gap)) + th_e;

    mv_x  = CW'(ox_e + EW'(speed_x_q));
    mv_y  = CW'(oy_e + EW'(speed_y_q));
    mvx_e = EW'(mv_x);
    mvy_e = EW'(mv_y);

    too_small = ((speed_x_q != '0) && (item_i.text_width < cfg_i.window_width)) ||
                ((speed_y_q != '0) && (item_i.text_height < cfg_i.window_height));
    // An empty window overlaps nothing
    hit   = (ww_m1 >= $signed(EW'(0))) && (wh_m1 >= $signed(EW'(0))) &&
            (ox_e <= ww_m1) && (ox_e + tw_e >= $signed(EW'(0))) &&
            (oy_e <= wh_m1) && (oy_e + th_e >= $signed(EW'(0)));
    rev_x = (lt_x && (ox_e + tw_e <= ww_m1)) || (gt_x && (ox_e >= $signed(EW'(0))));
    rev_y = (lt_y && (oy_e + th_e <= wh_m1)) || (gt_y && (oy_e >= $signed(EW'(0))));

    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    speed_x_d = speed_x_q;
    speed_y_d = speed_y_q;
    pause_d   = pause_q;

    result_o.offset_x   = coord_to_out(pos_x_q);
    result_o.offset_y   = coord_to_out(pos_y_q);
    result_o.repeat_x   = '0;
    result_o.repeat_y   = '0;
    result_o.active     = 1'b1;
    result_o.unscrolled = 1'b0;

    if (item_i.restart) begin
      speed_x_d = cfg_i.start_speed_x;
      speed_y_d = cfg_i.start_speed_y;
      pos_x_d   = rst_x;
      pos_y_d   = rst_y;
      pause_d   = PAUSE_WIDTH'(1);
      result_o.offset_x = coord_to_out(rst_x);
      result_o.offset_y = coord_to_out(rst_y);
    end else if (cfg_i.mode == MODE_NONE) begin
      result_o.offset_x = '0;
      result_o.offset_y = '0;
    end else if ((cfg_i.mode == MODE_BOUNCE) && too_small) begin
      result_o.offset_x   = '0;
      result_o.offset_y   = '0;
      result_o.unscrolled = 1'b1;
    end else if (pause_q != '0) begin
      pause_d = pause_q - PAUSE_WIDTH'(1);
    end else begin
      pos_x_d = mv_x;
      pos_y_d = mv_y;
      result_o.repeat_x = ext_to_out(nx_e);
      result_o.repeat_y = ext_to_out(ny_e);
      if (cfg_i.mode == MODE_BOUNCE) begin
        if (rev_x) begin
          speed_x_d = neg_speed(speed_x_q);
          pause_d   = cfg_i.pause_len;
        end
        if (rev_y) begin
          speed_y_d = neg_speed(speed_y_q);
          pause_d   = cfg_i.pause_len;
        end
      end else if (!hit) begin
        if (cfg_i.mode == MODE_WRAP) begin
          // Jump back by one period
          pos_x_d = CW'(mvx_e + nx_e);
          pos_y_d = CW'(mvy_e + ny_e);
        end else begin
          result_o = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      speed_x_q <= '0;
      speed_y_q <= '0;
      pause_q   <= '0;
    end else if (step_i) begin
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      speed_x_q <= speed_x_d;
      speed_y_q <= speed_y_d;
      pause_q   <= pause_d;
    end
  end

endmodule

### src/marquee_scroll_stepper.sv
// Top level of the marquee scroll stepper: input register, update core, result register.
//
//   channel  direction  transaction carries
//   in_i     sink       restart, text_width, text_height
//   out_o    source     offset_x/y, repeat_x/y, active, unscrolled
//   cfg_i    sink       register index, write data (always ready)
//
// Throughput is one transaction per cycle while out_o is not stalled; a result passes
// through the input register, then the result register, before it is valid.
// The scroll state updates in one pass of the core when an item moves from
// the input register into the result register.
// A stalled result register holds the item in the input register; the input
// register still takes a new item whenever it is empty.
// rst_ni clears configuration, scroll state and both valid flags.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module marquee_scroll_stepper import mss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  mss_in_if.sink   in_i,
  mss_out_if.source out_o,
  mss_cfg_if.sink  cfg_i
);

  cfg_t    cfg;
  item_t   item_q;
  result_t res_d, res_q;
  logic    s1_valid_q, out_valid_q;
  logic    advance, in_ready;
  logic    res_blank;

  mss_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  mss_step_core u_step_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .item_i   (item_q),
    .result_o (res_d)
  );

  assign advance  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || advance;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      item_q.restart     <= in_i.restart;
      item_q.text_width  <= in_i.text_width;
      item_q.text_height <= in_i.text_height;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.offset_x   = res_q.offset_x;
  assign out_o.offset_y   = res_q.offset_y;
  assign out_o.repeat_x   = res_q.repeat_x;
  assign out_o.repeat_y   = res_q.repeat_y;
  assign out_o.active     = res_q.active;
  assign out_o.unscrolled = res_q.unscrolled;

  assign res_blank = (res_q.offset_x == '0) && (res_q.offset_y == '0) &&
                     (res_q.repeat_x == '0) && (res_q.repeat_y == '0) &&
                     !res_q.unscrolled;

  // A finished one-pass result carries no offset or step
  `MSS_ASSERT(a_inactive_zero, (out_valid_q && !res_q.active) |-> res_blank)
  // Unshifted text is always drawn
  `MSS_ASSERT(a_unscrolled_active, (out_valid_q && res_q.unscrolled) |-> res_q.active)
  // An occupied input register only takes a new item when it is moving on
  `MSS_ASSERT(a_no_overwrite, (in_ready && s1_valid_q) |-> advance)
  // A stalled result stays valid into the next cycle
  `MSS_ASSERT(a_result_held, (out_valid_q && !out_o.ready) |=> out_valid_q)

endmodule
